FILE: design/z80_alu_with_flags_top_assert.svh
// assertion macros for the z80 alu checker
// expects clk and arst_n in the scope that uses them
`ifndef Z80_ALU_WITH_FLAGS_TOP_ASSERT_SVH
`define Z80_ALU_WITH_FLAGS_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define Z80A_ASSERT_NOW(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define Z80A_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

// check that also holds while reset is asserted
`define Z80A_ASSERT_ALWAYS(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) (expr)) else $error(msg);

`endif

FILE: design/z80alu_pkg.sv
// shared types and codes for the z80 alu with flag register
// no dependencies
`default_nettype none

package z80alu_pkg;

	// operation codes
	localparam logic [4:0] OP_ADD = 5'd0;
	localparam logic [4:0] OP_SUB = 5'd1;
	localparam logic [4:0] OP_CP  = 5'd2;
	localparam logic [4:0] OP_AND = 5'd3;
	localparam logic [4:0] OP_OR  = 5'd4;
	localparam logic [4:0] OP_XOR = 5'd5;
	localparam logic [4:0] OP_INC = 5'd6;
	localparam logic [4:0] OP_DEC = 5'd7;
	localparam logic [4:0] OP_BIT = 5'd8;
	localparam logic [4:0] OP_RES = 5'd9;
	localparam logic [4:0] OP_SET = 5'd10;
	localparam logic [4:0] OP_RL  = 5'd11;
	localparam logic [4:0] OP_RLC = 5'd12;
	localparam logic [4:0] OP_RR  = 5'd13;
	localparam logic [4:0] OP_RRC = 5'd14;
	localparam logic [4:0] OP_SLA = 5'd15;
	localparam logic [4:0] OP_SLL = 5'd16;
	localparam logic [4:0] OP_SRA = 5'd17;
	localparam logic [4:0] OP_SRL = 5'd18;
	localparam logic [4:0] OP_IN  = 5'd19;

	// flag bit positions, s z y h x pv n c from bit 7 down
	localparam int unsigned F_S = 7;
	localparam int unsigned F_Z = 6;
	localparam int unsigned F_Y = 5;
	localparam int unsigned F_H = 4;
	localparam int unsigned F_X = 3;
	localparam int unsigned F_P = 2;
	localparam int unsigned F_N = 1;
	localparam int unsigned F_C = 0;

	typedef struct packed {
		logic [4:0] op;
		logic [7:0] operand_a;
		logic [7:0] operand_b;
		logic [2:0] bit_index;
		logic       carry_in;
	} req_t;

	typedef struct packed {
		logic [7:0] result;
		logic [7:0] flags_out;
	} rsp_t;

endpackage

`default_nettype wire

FILE: design/z80alu_core.sv
// combinational datapath of the z80 alu: result byte and new flags
// depends on z80alu_pkg
`default_nettype none

module z80alu_core (
	input  z80alu_pkg::req_t   req,
	input  logic [7:0]         flags_cur,
	output z80alu_pkg::rsp_t   rsp
);
	import z80alu_pkg::*;

	// s z y x from a byte, h, pv, n and c supplied
	function automatic logic [7:0] szyx_flags(input logic [7:0] v, input logic h,
			input logic p, input logic n, input logic c);
		szyx_flags = {v[7], (v == 8'h00), v[5], h, v[3], p, n, c};
	endfunction

	// logic, rotate, shift and in: pv is even parity
	function automatic logic [7:0] logic_flags(input logic [7:0] v, input logic h,
			input logic c);
		logic_flags = szyx_flags(v, h, ~^v, 1'b0, c);
	endfunction

	logic [7:0] a;
	logic [7:0] b;
	logic       cf;
	logic [7:0] mask;
	logic [8:0] sum9;
	logic [8:0] diff9;
	logic       sub_cin;
	logic [7:0] r;
	logic [7:0] f;
	logic [7:0] inc_r;
	logic [7:0] dec_r;
	logic [7:0] tst;

	assign a       = req.operand_a;
	assign b       = req.operand_b;
	assign cf      = flags_cur[F_C];
	assign mask    = 8'h01 << req.bit_index;
	// compare ignores the borrow in
	assign sub_cin = (req.op == OP_CP) ? 1'b0 : req.carry_in;
	assign sum9    = {1'b0, a} + {1'b0, b} + {8'h00, req.carry_in};
	assign diff9   = {1'b0, a} - {1'b0, b} - {8'h00, sub_cin};
	assign inc_r   = a + 8'h01;
	assign dec_r   = a - 8'h01;
	assign tst     = a & mask;

	always_comb begin
		r = a;
		f = flags_cur;
		case (req.op)
			OP_ADD: begin
				r = sum9[7:0];
				f = szyx_flags(r, a[4] ^ b[4] ^ r[4],
					~(a[7] ^ b[7]) & (a[7] ^ r[7]), 1'b0, sum9[8]);
			end
			OP_SUB: begin
				r = diff9[7:0];
				f = szyx_flags(r, a[4] ^ b[4] ^ r[4],
					(a[7] ^ b[7]) & (a[7] ^ r[7]), 1'b1, diff9[8]);
			end
			OP_CP: begin
				// flags of a - b, but y and x from operand b, result is a
				f = szyx_flags(diff9[7:0], a[4] ^ b[4] ^ diff9[4],
					(a[7] ^ b[7]) & (a[7] ^ diff9[7]), 1'b1, diff9[8]);
				f[F_Y] = b[F_Y];
				f[F_X] = b[F_X];
			end
			OP_AND: begin
				r = a & b;
				f = logic_flags(r, 1'b1, 1'b0);
			end
			OP_OR: begin
				r = a | b;
				f = logic_flags(r, 1'b0, 1'b0);
			end
			OP_XOR: begin
				r = a ^ b;
				f = logic_flags(r, 1'b0, 1'b0);
			end
			OP_INC: begin
				r = inc_r;
				f = szyx_flags(r, (r[3:0] == 4'h0), (r == 8'h80), 1'b0, cf);
			end
			OP_DEC: begin
				r = dec_r;
				f = szyx_flags(r, (r[3:0] == 4'hf), (r == 8'h7f), 1'b1, cf);
			end
			OP_BIT: begin
				f = {tst[7], (tst == 8'h00), a[5], 1'b1, a[3], (tst == 8'h00), 1'b0, cf};
			end
			OP_RES: r = a & ~mask;
			OP_SET: r = a | mask;
			OP_RL: begin
				r = {a[6:0], cf};
				f = logic_flags(r, 1'b0, a[7]);
			end
			OP_RLC: begin
				r = {a[6:0], a[7]};
				f = logic_flags(r, 1'b0, a[7]);
			end
			OP_RR: begin
				r = {cf, a[7:1]};
				f = logic_flags(r, 1'b0, a[0]);
			end
			OP_RRC: begin
				r = {a[0], a[7:1]};
				f = logic_flags(r, 1'b0, a[0]);
			end
			OP_SLA: begin
				r = {a[6:0], 1'b0};
				f = logic_flags(r, 1'b0, a[7]);
			end
			OP_SLL: begin
				r = {a[6:0], 1'b1};
				f = logic_flags(r, 1'b0, a[7]);
			end
			OP_SRA: begin
				r = {a[7], a[7:1]};
				f = logic_flags(r, 1'b0, a[0]);
			end
			OP_SRL: begin
				r = {1'b0, a[7:1]};
				f = logic_flags(r, 1'b0, a[0]);
			end
			OP_IN: f = logic_flags(a, 1'b0, cf);
			default: begin
				// unused codes pass operand a, flags kept
				r = a;
				f = flags_cur;
			end
		endcase
	end

	assign rsp.result    = r;
	assign rsp.flags_out = f;

endmodule

`default_nettype wire

FILE: design/z80_alu_with_flags_top.sv
// top level of the z80 8-bit alu with stored flag register
// depends on z80alu_pkg and z80alu_core
//
//   channel   dir   handshake             payload
//   in        in    in_valid / in_ready   in_data   (z80alu_pkg::req_t)
//   out       out   out_valid / out_ready out_data  (z80alu_pkg::rsp_t)
//
// one request per cycle sustained while the output keeps taking results; a request
// taken into the input register moves on to the result register when the output is free
// the flag register is read and written as a request moves from the input
// register to the result register, so back-to-back requests see fresh flags
// arst_n clears both valid bits and the flag register to zero
// with the result register held the input register still takes one request
`default_nettype none

module z80_alu_with_flags_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  z80alu_pkg::req_t   in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output z80alu_pkg::rsp_t   out_data
);
	import z80alu_pkg::*;

	// input stage
	req_t       req_s1;
	logic       valid_s1;
	// result stage
	rsp_t       rsp_q;
	logic       out_valid_q;
	// architectural flag register
	logic [7:0] flag_q;

	rsp_t       rsp_next;
	logic       advance;

	// request in the input register moves on when the result slot is free
	// or is being emptied in this cycle
	assign advance  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			req_s1 <= in_data;
		end
	end

	// datapath sees the flags left by the previous request
	z80alu_core u_core (
		.req       (req_s1),
		.flags_cur (flag_q),
		.rsp       (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			flag_q      <= 8'h00;
		end else begin
			if (advance) begin
				out_valid_q <= 1'b1;
				flag_q      <= rsp_next.flags_out;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = rsp_q;

endmodule

`default_nettype wire

FILE: design/z80alu_checker.sv
// port-level checks for the z80 alu top level, bound in below
// depends on z80alu_pkg and z80_alu_with_flags_top_assert.svh
`default_nettype none

`include "z80_alu_with_flags_top_assert.svh"

module z80alu_checker (
	input logic             clk,
	input logic             arst_n,
	input logic             in_valid,
	input logic             in_ready,
	input z80alu_pkg::req_t in_data,
	input logic             out_valid,
	input logic             out_ready,
	input z80alu_pkg::rsp_t out_data
);
	import z80alu_pkg::*;

	// no result shows in the cycle after reset is seen
	`Z80A_ASSERT_ALWAYS(a_reset_idle, !arst_n |=> !out_valid, "result valid during reset")

	// a stalled result holds its value
	`Z80A_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "stalled result changed")

	// requests are only held off while a result waits
	`Z80A_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "request stalled with empty output")

	// an accepted request keeps the output busy once it has passed the input register
	`Z80A_ASSERT_NEXT(a_latency, in_valid && in_ready, 1'b1 ##1 out_valid, "request lost in pipeline")

endmodule

bind z80_alu_with_flags_top z80alu_checker u_checker (.*);

`default_nettype wire

FILE: tb/z80alu_tb_pkg.sv
`timescale 1ns / 100ps
// result board for the z80 alu testbench: flag-tracking predictor and result queue
// depends on z80alu_pkg for the request and response types and the op codes

package z80alu_tb_pkg;

	import z80alu_pkg::*;

	typedef struct {
		req_t rq;
		rsp_t rs;
	} outcome_t;

	class alu_result_board;

		logic [7:0]  flags;
		outcome_t    awaited[$];
		int unsigned errors;
		int unsigned checked;

		function new();
			flags   = 8'h00;
			errors  = 0;
			checked = 0;
		endfunction

		// s, z, y, x taken from a byte
		static function logic [7:0] szyx(logic [7:0] v);
			logic [7:0] f;
			f      = 8'h00;
			f[F_S] = v[7];
			f[F_Z] = (v == 8'h00);
			f[F_Y] = v[5];
			f[F_X] = v[3];
			return f;
		endfunction

		// flags shared by logic ops, rotates, shifts and in
		static function logic [7:0] logic_flags(logic [7:0] v, logic h, logic c);
			logic [7:0] f;
			f      = szyx(v);
			f[F_P] = ~^v;
			f[F_H] = h;
			f[F_C] = c;
			return f;
		endfunction

		// works out result and new flags, and moves the tracked flags on
		function rsp_t compute_outcome(req_t rq);
			logic [7:0] a, b, r, f, m;
			logic [8:0] z;
			logic       cf, cin;
			rsp_t       rs;
			a   = rq.operand_a;
			b   = rq.operand_b;
			cin = rq.carry_in;
			f   = flags;
			cf  = flags[F_C];
			r   = a;
			case (rq.op)
				OP_ADD: begin
					z      = {1'b0, a} + {1'b0, b} + {8'h00, cin};
					r      = z[7:0];
					f      = szyx(r);
					f[F_H] = a[4] ^ b[4] ^ r[4];
					f[F_P] = ~(a[7] ^ b[7]) & (a[7] ^ r[7]);
					f[F_C] = z[8];
				end
				OP_SUB, OP_CP: begin
					if (rq.op == OP_CP) begin
						cin = 1'b0;
					end
					z      = {1'b0, a} - {1'b0, b} - {8'h00, cin};
					r      = z[7:0];
					f      = szyx(r);
					f[F_H] = a[4] ^ b[4] ^ r[4];
					f[F_P] = (a[7] ^ b[7]) & (a[7] ^ r[7]);
					f[F_N] = 1'b1;
					f[F_C] = z[8];
					if (rq.op == OP_CP) begin
						// compare keeps a and takes the undocumented bits from b
						f[F_Y] = b[5];
						f[F_X] = b[3];
						r      = a;
					end
				end
				OP_AND: begin
					r = a & b;
					f = logic_flags(r, 1'b1, 1'b0);
				end
				OP_OR: begin
					r = a | b;
					f = logic_flags(r, 1'b0, 1'b0);
				end
				OP_XOR: begin
					r = a ^ b;
					f = logic_flags(r, 1'b0, 1'b0);
				end
				OP_INC: begin
					r      = a + 8'h01;
					f      = szyx(r);
					f[F_H] = (r[3:0] == 4'h0);
					f[F_P] = (r == 8'h80);
					f[F_C] = cf;
				end
				OP_DEC: begin
					r      = a - 8'h01;
					f      = szyx(r);
					f[F_H] = (r[3:0] == 4'hf);
					f[F_P] = (r == 8'h7f);
					f[F_N] = 1'b1;
					f[F_C] = cf;
				end
				OP_BIT: begin
					m      = a & (8'h01 << rq.bit_index);
					f      = 8'h00;
					f[F_S] = m[7];
					f[F_Z] = (m == 8'h00);
					f[F_P] = (m == 8'h00);
					f[F_Y] = a[5];
					f[F_X] = a[3];
					f[F_H] = 1'b1;
					f[F_C] = cf;
				end
				OP_RES: r = a & ~(8'h01 << rq.bit_index);
				OP_SET: r = a | (8'h01 << rq.bit_index);
				OP_RL: begin
					r = {a[6:0], cf};
					f = logic_flags(r, 1'b0, a[7]);
				end
				OP_RLC: begin
					r = {a[6:0], a[7]};
					f = logic_flags(r, 1'b0, a[7]);
				end
				OP_RR: begin
					r = {cf, a[7:1]};
					f = logic_flags(r, 1'b0, a[0]);
				end
				OP_RRC: begin
					r = {a[0], a[7:1]};
					f = logic_flags(r, 1'b0, a[0]);
				end
				OP_SLA: begin
					r = {a[6:0], 1'b0};
					f = logic_flags(r, 1'b0, a[7]);
				end
				OP_SLL: begin
					r = {a[6:0], 1'b1};
					f = logic_flags(r, 1'b0, a[7]);
				end
				OP_SRA: begin
					r = {a[7], a[7:1]};
					f = logic_flags(r, 1'b0, a[0]);
				end
				OP_SRL: begin
					r = {1'b0, a[7:1]};
					f = logic_flags(r, 1'b0, a[0]);
				end
				OP_IN: begin
					r = a;
					f = logic_flags(r, 1'b0, cf);
				end
				default: r = a;
			endcase
			flags        = f;
			rs.result    = r;
			rs.flags_out = f;
			return rs;
		endfunction

		function void note_request(req_t rq);
			outcome_t o;
			o.rq = rq;
			o.rs = compute_outcome(rq);
			awaited.push_back(o);
		endfunction

		function void report(string field, req_t rq, logic [7:0] want, logic [7:0] got);
			errors++;
			if (errors <= 10) begin
				$display("mismatch in %s: op %0d a %02h b %02h bit %0d cin %0b: want %02h got %02h",
					field, rq.op, rq.operand_a, rq.operand_b, rq.bit_index, rq.carry_in,
					want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			outcome_t o;
			checked++;
			if (awaited.size() == 0) begin
				errors++;
				if (errors <= 10) begin
					$display("unexpected result %02h flags %02h", got.result, got.flags_out);
				end
				return;
			end
			o = awaited.pop_front();
			if (got.result !== o.rs.result) begin
				report("result", o.rq, o.rs.result, got.result);
			end
			if (got.flags_out !== o.rs.flags_out) begin
				report("flags", o.rq, o.rs.flags_out, got.flags_out);
			end
		endfunction

	endclass

endpackage

FILE: tb/z80_alu_with_flags_top_tb.sv
`timescale 1ns / 100ps
// testbench for z80_alu_with_flags_top: directed then random requests, checked by a result board
// depends on z80alu_pkg and z80alu_tb_pkg

module z80_alu_with_flags_top_tb;

	import z80alu_pkg::*;
	import z80alu_tb_pkg::*;

	// cycles with no handshake on either side before the run is called hung;
	// the longest legal quiet stretch is the long receiver hold plus a gap
	localparam int unsigned STALL_LIMIT = 5000;
	localparam int unsigned RANDOM_REQS = 1500;
	// a request passes the input register and the result register to reach the output, so a short tail is plenty
	localparam int unsigned DRAIN_CYCLES = 10;
	// long receiver hold so the input register and result register both fill
	localparam int unsigned HOLD_AFTER = 400;
	localparam int unsigned HOLD_CYCLES = 200;

	logic clk      = 1'b0;
	logic arst_n   = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	req_t in_data  = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	rsp_t out_data;

	alu_result_board board;
	req_t            directed[$];

	z80_alu_with_flags_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// idle length: mostly none, some short, a few long
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 60) begin
			return 0;
		end
		if (roll < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 30);
	endfunction

	function automatic req_t make_req(logic [4:0] op, logic [7:0] a, logic [7:0] b,
		logic [2:0] bi, logic cin);
		req_t rq;
		rq.op        = op;
		rq.operand_a = a;
		rq.operand_b = b;
		rq.bit_index = bi;
		rq.carry_in  = cin;
		return rq;
	endfunction

	// mostly real operations, the odd unused code among them
	function automatic req_t random_req();
		logic [4:0] op;
		if ($urandom_range(0, 9) == 0) begin
			op = 5'($urandom_range(20, 31));
		end else begin
			op = 5'($urandom_range(0, 19));
		end
		return make_req(op, 8'($urandom), 8'($urandom), 3'($urandom), 1'($urandom));
	endfunction

	// one request: optional idle gap, then hold valid and payload until taken
	task automatic send_request(req_t rq, int unsigned gap);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= rq;
		do @(posedge clk); while (!in_ready);
		board.note_request(rq);
	endtask

	// extremes of every field and the corner cases of each flag group;
	// ordering matters where a rotate picks up the carry left by the op before
	task automatic fill_directed();
		directed.push_back(make_req(OP_ADD, 8'h7f, 8'h01, 3'd0, 1'b0)); // signed overflow, half carry
		directed.push_back(make_req(OP_ADD, 8'hff, 8'h00, 3'd7, 1'b1)); // carry in wraps to zero
		directed.push_back(make_req(OP_SUB, 8'h80, 8'h01, 3'd0, 1'b0)); // signed overflow
		directed.push_back(make_req(OP_SUB, 8'h00, 8'h00, 3'd0, 1'b1)); // borrow in gives 0xff
		directed.push_back(make_req(OP_CP,  8'h10, 8'h28, 3'd0, 1'b1)); // y, x from b, cin ignored
		directed.push_back(make_req(OP_AND, 8'hff, 8'hff, 3'd0, 1'b0));
		directed.push_back(make_req(OP_OR,  8'h00, 8'h00, 3'd0, 1'b0)); // zero, even parity
		directed.push_back(make_req(OP_XOR, 8'ha5, 8'hff, 3'd0, 1'b0));
		directed.push_back(make_req(OP_INC, 8'h7f, 8'h00, 3'd0, 1'b0)); // to 0x80
		directed.push_back(make_req(OP_DEC, 8'h80, 8'h00, 3'd0, 1'b0)); // to 0x7f
		directed.push_back(make_req(OP_BIT, 8'h80, 8'h00, 3'd7, 1'b0)); // bit 7 set gives s
		directed.push_back(make_req(OP_BIT, 8'hf7, 8'h00, 3'd3, 1'b0)); // tested bit clear
		directed.push_back(make_req(OP_RES, 8'hff, 8'h00, 3'd0, 1'b0));
		directed.push_back(make_req(OP_SET, 8'h00, 8'h00, 3'd7, 1'b0));
		directed.push_back(make_req(OP_RL,  8'h80, 8'h00, 3'd0, 1'b0)); // carry out
		directed.push_back(make_req(OP_RR,  8'h00, 8'h00, 3'd0, 1'b0)); // stored carry into bit 7
		directed.push_back(make_req(OP_RRC, 8'h01, 8'h00, 3'd0, 1'b0));
		directed.push_back(make_req(OP_RLC, 8'h80, 8'h00, 3'd0, 1'b0));
		directed.push_back(make_req(OP_SLA, 8'hff, 8'h00, 3'd0, 1'b0));
		directed.push_back(make_req(OP_SLL, 8'h00, 8'h00, 3'd0, 1'b0)); // one into bit 0
		directed.push_back(make_req(OP_SRA, 8'h80, 8'h00, 3'd0, 1'b0));
		directed.push_back(make_req(OP_SRL, 8'h01, 8'h00, 3'd0, 1'b0));
		directed.push_back(make_req(OP_IN,  8'h00, 8'h00, 3'd0, 1'b0)); // keeps carry
		directed.push_back(make_req(5'd31,  8'h5a, 8'hff, 3'd7, 1'b1)); // unused code, flags kept
	endtask

	// stimulus and end of run
	initial begin
		bit tx_steady;
		board = new();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		fill_directed();
		foreach (directed[i]) begin
			send_request(directed[i], pick_gap());
		end

		// blocks of a hundred requests, now and then sent back to back
		tx_steady = 1'b0;
		for (int unsigned n = 0; n < RANDOM_REQS; n++) begin
			if (n % 100 == 0) begin
				tx_steady = ($urandom_range(0, 3) == 0);
			end
			send_request(random_req(), tx_steady ? 0 : pick_gap());
		end
		in_valid <= 1'b0;

		while (board.awaited.size() != 0) @(posedge clk);
		// catch anything extra the block might still emit
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (board.errors == 0 && board.awaited.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// receiver: checks every accepted response, then picks ready for the next edge
	initial begin
		int unsigned stall_left;
		int unsigned phase_left;
		bit          rx_steady;
		bit          held_long;
		stall_left = 0;
		phase_left = $urandom_range(50, 300);
		rx_steady  = 1'b0;
		held_long  = 1'b0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				board.check_result(out_data);
			end
			// alternate stretches of always-ready with stretches of random stalls
			if (phase_left == 0) begin
				rx_steady  = ~rx_steady;
				phase_left = $urandom_range(50, 300);
			end else begin
				phase_left--;
			end
			// one long hold while the sender keeps offering, to back up the pipe
			if (!held_long && board.checked >= HOLD_AFTER) begin
				held_long  = 1'b1;
				stall_left = HOLD_CYCLES;
			end
			if (stall_left != 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if (rx_steady) begin
				out_ready <= 1'b1;
			end else begin
				stall_left = pick_gap();
				out_ready  <= (stall_left == 0);
			end
		end
	end

	// watchdog: quiet cycles on both channels
	initial begin
		int unsigned quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("timeout after %0d quiet cycles", STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

endmodule
